>>> rtl/ogpd_pkg.sv
// Package for the Ogg page deframer: phase and result codes, header layout
// constants and the lacing table entry format. Depends on nothing.
package ogpd_pkg;

  localparam int LACING_DEPTH_DEF = 255;
  localparam int HEADER_BYTES     = 27;

  localparam logic [4:0]  POS_TYPE     = 5'd5;
  localparam logic [4:0]  POS_GRANULE  = 5'd6;
  localparam logic [4:0]  POS_SERIAL   = 5'd14;
  localparam logic [4:0]  POS_SEQUENCE = 5'd18;
  localparam logic [4:0]  POS_COUNT    = 5'(HEADER_BYTES - 1);
  localparam logic [4:0]  CAPTURE_LEN  = 5'd4;
  localparam logic [7:0]  FULL_LACING  = 8'd255;
  localparam logic [15:0] LIMIT_RESET  = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_EXPECT,
    PH_HEADER,
    PH_LACING,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PAGE,
    KIND_CAPTURE,
    KIND_OVERSIZE
  } kind_t;

  // Nonzero lacing value, marked when one or more zero values preceded it.
  typedef struct packed {
    logic       zero_before;
    logic [7:0] lacing;
  } lac_entry_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    lac_entry_t data;
  } lac_wr_t;

  function automatic logic [7:0] capture_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h4F;
      2'd1:    r = 8'h67;
      2'd2:    r = 8'h67;
      default: r = 8'h53;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ogpd_lacing_ram.sv
// Lacing table memory of the Ogg page deframer: one write port and one
// registered read port with write-through forwarding. Depends on ogpd_pkg.
module ogpd_lacing_ram #(
  parameter int DEPTH = ogpd_pkg::LACING_DEPTH_DEF
) (
  input  logic                 clk,
  input  ogpd_pkg::lac_wr_t    wr,
  input  logic [7:0]           raddr,
  output ogpd_pkg::lac_entry_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ogpd_pkg::lac_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == raddr)) begin
      rdata <= wr.data;
    end else begin
      rdata <= mem[raddr[AW-1:0]];
    end
  end

endmodule

>>> rtl/ogg_page_deframer.sv
// Top level of the Ogg page deframer: header capture, lacing table walk and
// payload marking. Depends on ogpd_pkg and ogpd_lacing_ram.
//
//   channel   signals                                   direction
//   input     in_valid, in_ready, stream_byte           byte stream in
//   output    out_valid, out_ready, kind ... packet_length  results out
//   config    cfg_valid, cfg_ready, cfg_data            packet_limit write
//
// A new byte can be taken each cycle unless a held result stalls the input.
// Zero lacing values are folded into the stored table entries, so one memory
// read a cycle keeps the payload walk at one byte per cycle unless stalled.
// Reset clears all control state; packet_limit returns to 65535.
// A held result stalls the input until it is taken.
module ogg_page_deframer #(
  parameter int LACING_DEPTH = ogpd_pkg::LACING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic        first_of_packet,
  output logic        last_of_packet,
  output logic [63:0] granule_position,
  output logic [31:0] stream_serial,
  output logic [31:0] page_sequence,
  output logic [7:0]  header_type,
  output logic [7:0]  segment_count,
  output logic [15:0] packet_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  ogpd_pkg::phase_t phase, phase_next;
  logic [4:0]  header_position, header_position_next;
  logic [63:0] granule_reg, granule_reg_next;
  logic [31:0] serial_reg, serial_reg_next;
  logic [31:0] sequence_reg, sequence_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  count_reg, count_reg_next;
  logic [7:0]  segment_index, segment_index_next;
  logic [7:0]  fill_count, fill_count_next;
  logic        zero_pending, zero_pending_next;
  logic [7:0]  nonzero_count, nonzero_count_next;
  logic        trail_zero, trail_zero_next;
  logic [7:0]  read_ptr, read_ptr_next;
  logic [7:0]  segment_remaining, segment_remaining_next;
  logic [7:0]  current_lacing, current_lacing_next;
  logic [15:0] packet_count, packet_count_next;
  logic        packet_open, packet_open_next;
  logic        discarding, discarding_next;
  logic [15:0] packet_limit;

  ogpd_pkg::kind_t out_kind;

  logic        accept;
  logic [7:0]  lac_eff;
  logic        final_lacing;
  logic [7:0]  fill_count_lac;
  logic        zero_pending_lac;
  logic        over_limit;
  logic        first_mark;
  logic        last_mark;
  logic [7:0]  remaining_dec;

  logic [7:0]  ns_ptr;
  logic [7:0]  ns_count;
  logic        ns_tz;
  logic        ns_found;
  logic        ns_close;
  ogpd_pkg::lac_entry_t ns_entry;
  ogpd_pkg::lac_entry_t rd_data;
  ogpd_pkg::lac_wr_t    lac_wr;

  logic            res_valid;
  ogpd_pkg::kind_t res_kind;
  logic [7:0]      res_data;
  logic            res_first;
  logic            res_last;
  logic [15:0]     res_length;

  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign lac_eff = ({1'b0, segment_index} < 9'(LACING_DEPTH)) ? stream_byte : 8'd0;
  assign final_lacing = ({1'b0, segment_index} + 9'd1) >= {1'b0, count_reg};
  assign fill_count_lac   = fill_count + {7'd0, (lac_eff != 8'd0)};
  assign zero_pending_lac = (lac_eff == 8'd0);

  assign lac_wr.en   = accept && (phase == ogpd_pkg::PH_LACING) && (lac_eff != 8'd0);
  assign lac_wr.addr = fill_count;
  assign lac_wr.data = '{zero_before: zero_pending, lacing: lac_eff};

  always_comb begin
    if (phase == ogpd_pkg::PH_LACING) begin
      ns_ptr   = 8'd0;
      ns_count = fill_count_lac;
      ns_tz    = zero_pending_lac;
      ns_entry = ((fill_count == 8'd0) && (lac_eff != 8'd0)) ? lac_wr.data : rd_data;
    end else begin
      ns_ptr   = read_ptr;
      ns_count = nonzero_count;
      ns_tz    = trail_zero;
      ns_entry = rd_data;
    end
  end

  assign ns_found = ns_ptr < ns_count;
  assign ns_close = ns_found ? ns_entry.zero_before : ns_tz;

  assign over_limit    = ({1'b0, packet_count} + 17'd1) > {1'b0, packet_limit};
  assign first_mark    = !packet_open;
  assign last_mark     = (segment_remaining == 8'd1) &&
                         (current_lacing < ogpd_pkg::FULL_LACING);
  assign remaining_dec = (segment_remaining != 8'd0) ? segment_remaining - 8'd1 : 8'd0;

  ogpd_lacing_ram #(
    .DEPTH(LACING_DEPTH)
  ) u_lacing_ram (
    .clk  (clk),
    .wr   (lac_wr),
    .raddr(read_ptr_next),
    .rdata(rd_data)
  );

  always_comb begin
    logic advance;
    logic close_req;
    advance                = 1'b0;
    close_req              = 1'b0;
    phase_next             = phase;
    header_position_next   = header_position;
    granule_reg_next       = granule_reg;
    serial_reg_next        = serial_reg;
    sequence_reg_next      = sequence_reg;
    type_reg_next          = type_reg;
    count_reg_next         = count_reg;
    segment_index_next     = segment_index;
    fill_count_next        = fill_count;
    zero_pending_next      = zero_pending;
    nonzero_count_next     = nonzero_count;
    trail_zero_next        = trail_zero;
    read_ptr_next          = read_ptr;
    segment_remaining_next = segment_remaining;
    current_lacing_next    = current_lacing;
    packet_count_next      = packet_count;
    packet_open_next       = packet_open;
    discarding_next        = discarding;
    if (accept) begin
      case (phase)
        ogpd_pkg::PH_HUNT, ogpd_pkg::PH_EXPECT: begin
          if ((header_position < ogpd_pkg::CAPTURE_LEN) &&
              (stream_byte == ogpd_pkg::capture_byte(header_position[1:0]))) begin
            header_position_next = header_position + 5'd1;
            if (header_position_next == ogpd_pkg::CAPTURE_LEN) begin
              phase_next = ogpd_pkg::PH_HEADER;
            end
          end else begin
            header_position_next =
              {4'd0, (stream_byte == ogpd_pkg::capture_byte(2'd0))};
            phase_next = ogpd_pkg::PH_HUNT;
          end
        end
        ogpd_pkg::PH_HEADER: begin
          if (header_position == ogpd_pkg::POS_TYPE) begin
            type_reg_next = stream_byte;
          end else if (header_position inside
                       {[ogpd_pkg::POS_GRANULE:ogpd_pkg::POS_SERIAL - 5'd1]}) begin
            granule_reg_next[8*(3'(header_position - ogpd_pkg::POS_GRANULE)) +: 8] =
              stream_byte;
          end else if (header_position inside
                       {[ogpd_pkg::POS_SERIAL:ogpd_pkg::POS_SEQUENCE - 5'd1]}) begin
            serial_reg_next[8*(2'(header_position - ogpd_pkg::POS_SERIAL)) +: 8] =
              stream_byte;
          end else if (header_position inside
                       {[ogpd_pkg::POS_SEQUENCE:ogpd_pkg::POS_SEQUENCE + 5'd3]}) begin
            sequence_reg_next[8*(2'(header_position - ogpd_pkg::POS_SEQUENCE)) +: 8] =
              stream_byte;
          end
          if (header_position >= ogpd_pkg::POS_COUNT) begin
            count_reg_next       = stream_byte;
            segment_index_next   = 8'd0;
            header_position_next = 5'd0;
            fill_count_next      = 8'd0;
            zero_pending_next    = 1'b0;
            read_ptr_next        = 8'd0;
            phase_next = (stream_byte == 8'd0) ? ogpd_pkg::PH_EXPECT : ogpd_pkg::PH_LACING;
          end else begin
            header_position_next = header_position + 5'd1;
          end
        end
        ogpd_pkg::PH_LACING: begin
          segment_index_next = segment_index + 8'd1;
          fill_count_next    = fill_count_lac;
          zero_pending_next  = zero_pending_lac;
          if (final_lacing) begin
            segment_index_next = 8'd0;
            nonzero_count_next = fill_count_lac;
            trail_zero_next    = zero_pending_lac;
            advance            = 1'b1;
          end
        end
        ogpd_pkg::PH_PAYLOAD: begin
          packet_open_next = 1'b1;
          if (!discarding) begin
            if (over_limit) begin
              discarding_next = 1'b1;
            end else begin
              packet_count_next = packet_count + 16'd1;
            end
          end
          segment_remaining_next = remaining_dec;
          if (remaining_dec == 8'd0) begin
            close_req = (current_lacing < ogpd_pkg::FULL_LACING);
            advance   = 1'b1;
          end
        end
        default: begin
          phase_next           = ogpd_pkg::PH_HUNT;
          header_position_next = 5'd0;
        end
      endcase
      if (advance) begin
        close_req = close_req || ns_close;
        if (ns_found) begin
          current_lacing_next    = ns_entry.lacing;
          segment_remaining_next = ns_entry.lacing;
          read_ptr_next          = ns_ptr + 8'd1;
          phase_next             = ogpd_pkg::PH_PAYLOAD;
        end else begin
          phase_next           = ogpd_pkg::PH_EXPECT;
          header_position_next = 5'd0;
        end
      end
      if (close_req) begin
        packet_open_next  = 1'b0;
        packet_count_next = 16'd0;
        discarding_next   = 1'b0;
      end
    end
  end

  always_comb begin
    res_valid  = 1'b0;
    res_kind   = ogpd_pkg::KIND_DATA;
    res_data   = 8'd0;
    res_first  = 1'b0;
    res_last   = 1'b0;
    res_length = 16'd0;
    case (phase)
      ogpd_pkg::PH_EXPECT: begin
        if (!((header_position < ogpd_pkg::CAPTURE_LEN) &&
              (stream_byte == ogpd_pkg::capture_byte(header_position[1:0])))) begin
          res_valid = 1'b1;
          res_kind  = ogpd_pkg::KIND_CAPTURE;
        end
      end
      ogpd_pkg::PH_HEADER: begin
        if ((header_position >= ogpd_pkg::POS_COUNT) && (stream_byte == 8'd0)) begin
          res_valid = 1'b1;
          res_kind  = ogpd_pkg::KIND_PAGE;
        end
      end
      ogpd_pkg::PH_LACING: begin
        if (final_lacing) begin
          res_valid = 1'b1;
          res_kind  = ogpd_pkg::KIND_PAGE;
        end
      end
      ogpd_pkg::PH_PAYLOAD: begin
        if (!discarding) begin
          res_valid = 1'b1;
          if (over_limit) begin
            res_kind   = ogpd_pkg::KIND_OVERSIZE;
            res_length = packet_limit;
          end else begin
            res_kind   = ogpd_pkg::KIND_DATA;
            res_data   = stream_byte;
            res_first  = first_mark;
            res_last   = last_mark;
            res_length = packet_count + 16'd1;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= ogpd_pkg::PH_HUNT;
      header_position   <= 5'd0;
      granule_reg       <= 64'd0;
      serial_reg        <= 32'd0;
      sequence_reg      <= 32'd0;
      type_reg          <= 8'd0;
      count_reg         <= 8'd0;
      segment_index     <= 8'd0;
      fill_count        <= 8'd0;
      zero_pending      <= 1'b0;
      nonzero_count     <= 8'd0;
      trail_zero        <= 1'b0;
      read_ptr          <= 8'd0;
      segment_remaining <= 8'd0;
      current_lacing    <= 8'd0;
      packet_count      <= 16'd0;
      packet_open       <= 1'b0;
      discarding        <= 1'b0;
      packet_limit      <= ogpd_pkg::LIMIT_RESET;
      out_valid         <= 1'b0;
    end else begin
      phase             <= phase_next;
      header_position   <= header_position_next;
      granule_reg       <= granule_reg_next;
      serial_reg        <= serial_reg_next;
      sequence_reg      <= sequence_reg_next;
      type_reg          <= type_reg_next;
      count_reg         <= count_reg_next;
      segment_index     <= segment_index_next;
      fill_count        <= fill_count_next;
      zero_pending      <= zero_pending_next;
      nonzero_count     <= nonzero_count_next;
      trail_zero        <= trail_zero_next;
      read_ptr          <= read_ptr_next;
      segment_remaining <= segment_remaining_next;
      current_lacing    <= current_lacing_next;
      packet_count      <= packet_count_next;
      packet_open       <= packet_open_next;
      discarding        <= discarding_next;
      if (cfg_valid && cfg_ready) begin
        packet_limit <= cfg_data;
      end
      if (in_ready) begin
        out_valid <= accept && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind        <= res_kind;
      data_byte       <= res_data;
      first_of_packet <= res_first;
      last_of_packet  <= res_last;
      packet_length   <= res_length;
    end
  end

  // The page registers cannot change while a result is held, since no
  // request is taken until it leaves.
  assign kind             = out_kind;
  assign granule_position = granule_reg;
  assign stream_serial    = serial_reg;
  assign page_sequence    = sequence_reg;
  assign header_type      = type_reg;
  assign segment_count    = count_reg;

  a_payload_remaining: assert property (@(posedge clk) disable iff (rst)
    (phase == ogpd_pkg::PH_PAYLOAD) |-> (segment_remaining != 8'd0))
    else $error("payload phase with no bytes left in segment");

  a_read_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == ogpd_pkg::PH_PAYLOAD) |-> (read_ptr <= nonzero_count))
    else $error("lacing read pointer past stored entries");

  a_header_position: assert property (@(posedge clk) disable iff (rst)
    (phase == ogpd_pkg::PH_HEADER) |->
      ((header_position >= ogpd_pkg::CAPTURE_LEN) &&
       (header_position <= ogpd_pkg::POS_COUNT)))
    else $error("header position out of range in header phase");

  a_discard_open: assert property (@(posedge clk) disable iff (rst)
    discarding |-> packet_open)
    else $error("discarding without an open packet");

  a_data_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == ogpd_pkg::KIND_DATA)) |-> (packet_length != 16'd0))
    else $error("payload result with zero packet length");

endmodule
